### rtl/haversine_distance_macros.svh
// ---------------------------------------------------------------------------
// Haversine distance assertion macros
// Shared concurrent assertion forms for the distance pipeline checkers.
// ---------------------------------------------------------------------------
`ifndef HAVERSINE_DISTANCE_MACROS_SVH
`define HAVERSINE_DISTANCE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HVD_ASSERT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HVD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### rtl/hvd_pkg.sv
// ---------------------------------------------------------------------------
// Haversine distance package
// Widths, fixed-point constants and helper functions of the distance pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hvd_pkg;

	localparam int LAT_W   = 28;
	localparam int LON_W   = 29;
	localparam int ANG_W   = 30;
	localparam int DIST_W  = 25;
	localparam int CQ_W    = 33;
	localparam int PD_W    = 2 * CQ_W;
	localparam int Q30_FRAC = 30;
	localparam int SQ_W    = 31;
	localparam int SQ_REM_W = 61;
	localparam int SQ_STEPS = 31;

	typedef logic signed [CQ_W-1:0] cq_t;
	typedef logic signed [PD_W-1:0] prod_t;

	localparam cq_t CORDIC_GAIN = 33'sd652032874;

	// round(pi/180 * 2^35)
	localparam int DEG_RAD_W = 30;
	localparam logic [DEG_RAD_W-1:0] DEG_TO_RAD = 30'd599690565;

	// reciprocal of 45 for the modulo-360 reduction, Q24
	localparam int RECIP_W     = 20;
	localparam int RECIP_SHIFT = 24;
	localparam int RECIP45     = 372828;

	localparam int DIAM_W = 24;
	localparam logic [DIAM_W-1:0] DIAMETER_M = 24'd12742000;
	localparam logic [DIST_W-1:0] DIST_MAX = 25'd20015087;

	function automatic cq_t atan_q30(input int i);
		cq_t r;
		case (i)
			0: r = 33'sd843314857;
			1: r = 33'sd497837829;
			2: r = 33'sd263043837;
			3: r = 33'sd133525159;
			4: r = 33'sd67021687;
			5: r = 33'sd33543516;
			6: r = 33'sd16775851;
			7: r = 33'sd8388437;
			8: r = 33'sd4194283;
			9: r = 33'sd2097149;
			default: begin
				if (i <= 30) begin
					r = cq_t'(64'd1 << (30 - i));
				end else begin
					r = '0;
				end
			end
		endcase
		return r;
	endfunction

	// Q30 product rounded half up back to Q30
	function automatic cq_t q30_round(input prod_t p);
		prod_t t;
		t = p + (prod_t'(1) <<< (Q30_FRAC - 1));
		return cq_t'(t >>> Q30_FRAC);
	endfunction

	// register layers from request to result strobe
	function automatic int pipe_latency(input int stages);
		return 44 + 2 * stages;
	endfunction

endpackage

### rtl/hvd_sincos.sv
// ---------------------------------------------------------------------------
// Haversine sine/cosine lane
// Reduces a degree angle modulo 360, folds it to +-90, converts to Q30 radians
// and rotates a fully unrolled CORDIC, one iteration per register stage.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hvd_sincos #(
	parameter int ANGLE_FRAC_BITS = 20,
	parameter int CORDIC_STAGES = 32
) (
	input  logic                            clk,
	input  logic signed [hvd_pkg::ANG_W-1:0] angle,
	output hvd_pkg::cq_t                    sin_val,
	output hvd_pkg::cq_t                    cos_val
);
	import hvd_pkg::*;

	localparam int G     = ANGLE_FRAC_BITS + 1;
	localparam int LOW_W = G + 3;
	localparam int HW    = ANG_W - LOW_W;
	localparam int PW    = HW + RECIP_W;
	localparam int RMW   = HW + 7;
	localparam int RW    = G + 9;
	localparam int MW    = G + 7;
	localparam int PRW   = MW + DEG_RAD_W;
	localparam int RDW   = PRW + 1;
	localparam int NS    = CORDIC_STAGES;

	localparam logic [RW-1:0] QTR   = RW'(64'd90 << G);
	localparam logic [RW-1:0] HALF  = RW'(64'd180 << G);
	localparam logic [RW-1:0] TQTR  = RW'(64'd270 << G);
	localparam logic [RW-1:0] FULL  = RW'(64'd360 << G);
	localparam logic signed [PW-1:0]  RECIP = PW'(RECIP45);
	localparam logic signed [RMW-1:0] C45   = RMW'(45);

	// stage 1: split off the high part and multiply by 1/45
	logic signed [HW-1:0]  h_c;
	logic signed [HW-1:0]  h_s1;
	logic [LOW_W-1:0]      lo_s1;
	logic signed [PW-1:0]  prod_s1;

	assign h_c = HW'(angle >>> LOW_W);

	always_ff @(posedge clk) begin
		h_s1    <= h_c;
		lo_s1   <= angle[LOW_W-1:0];
		prod_s1 <= PW'(h_c) * RECIP;
	end

	// stage 2: floor modulo 45 of the high part, one correction step
	logic signed [HW-1:0]  q_c;
	logic signed [RMW-1:0] rem_c;
	logic [5:0]            remf_c;
	logic [RW-1:0]         r_s2;

	always_comb begin
		q_c   = HW'(prod_s1 >>> RECIP_SHIFT);
		rem_c = RMW'(h_s1) - RMW'(q_c) * C45;
		if (rem_c < 0) begin
			remf_c = 6'(rem_c + C45);
		end else if (rem_c >= C45) begin
			remf_c = 6'(rem_c - C45);
		end else begin
			remf_c = 6'(rem_c);
		end
	end

	always_ff @(posedge clk) begin
		r_s2 <= {remf_c, lo_s1};
	end

	// stage 3: fold into +-90 degrees, a fold flips the cosine
	logic signed [RW:0] f_c;
	logic               fold_c;
	logic [MW-1:0]      m_s3;
	logic               neg_s3;
	logic               negc_s3;

	always_comb begin
		if (r_s2 <= QTR) begin
			f_c    = $signed({1'b0, r_s2});
			fold_c = 1'b0;
		end else if (r_s2 < TQTR) begin
			f_c    = $signed({1'b0, HALF}) - $signed({1'b0, r_s2});
			fold_c = 1'b1;
		end else begin
			f_c    = $signed({1'b0, r_s2}) - $signed({1'b0, FULL});
			fold_c = 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		m_s3    <= MW'((f_c < 0) ? -f_c : f_c);
		neg_s3  <= (f_c < 0);
		negc_s3 <= fold_c;
	end

	// stage 4: degrees to radians, magnitude product
	logic [PRW-1:0] prod_s4;
	logic           neg_s4;
	logic           negc_s4;

	always_ff @(posedge clk) begin
		prod_s4 <= PRW'(m_s3) * PRW'(DEG_TO_RAD);
		neg_s4  <= neg_s3;
		negc_s4 <= negc_s3;
	end

	// stage 5: round to Q30, restore sign, seed the rotation
	logic [RDW-1:0] rsum_c;
	logic [30:0]    rad_c;
	cq_t            z0_c;

	always_comb begin
		rsum_c = {1'b0, prod_s4} + (RDW'(1) << (G + 4));
		rad_c  = rsum_c[G+5 +: 31];
		z0_c   = neg_s4 ? -cq_t'({2'b00, rad_c}) : cq_t'({2'b00, rad_c});
	end

	cq_t  xr_s [0:NS];
	cq_t  yr_s [0:NS];
	cq_t  zr_s [0:NS];
	logic nc_s [0:NS];

	always_ff @(posedge clk) begin
		xr_s[0] <= CORDIC_GAIN;
		yr_s[0] <= '0;
		zr_s[0] <= z0_c;
		nc_s[0] <= negc_s4;
	end

	for (genvar i = 0; i < NS; i++) begin : g_rot
		always_ff @(posedge clk) begin
			if (zr_s[i] >= 0) begin
				xr_s[i+1] <= xr_s[i] - (yr_s[i] >>> i);
				yr_s[i+1] <= yr_s[i] + (xr_s[i] >>> i);
				zr_s[i+1] <= zr_s[i] - atan_q30(i);
			end else begin
				xr_s[i+1] <= xr_s[i] + (yr_s[i] >>> i);
				yr_s[i+1] <= yr_s[i] - (xr_s[i] >>> i);
				zr_s[i+1] <= zr_s[i] + atan_q30(i);
			end
			nc_s[i+1] <= nc_s[i];
		end
	end

	assign sin_val = yr_s[NS];
	assign cos_val = nc_s[NS] ? -xr_s[NS] : xr_s[NS];

endmodule

### rtl/haversine_distance.sv
// ---------------------------------------------------------------------------
// Haversine great-circle distance
// Fully pipelined distance between two points on a 6371 km sphere, in metres.
// ---------------------------------------------------------------------------
//
// Channel   Direction  Handshake           Payload
// request   in         start / busy        lat_first lon_first lat_second lon_second
// result    out        done (one cycle)    distance_m
//
// One request may enter every cycle; busy stays low, the pipeline never stalls.
// Latency is set by the two unrolled CORDIC chains
// and the 31-step square root; each step owns one register stage.
// done is a single-cycle strobe; the receiver cannot hold results off.
// Reset clears the valid chain only; in-flight requests are dropped.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module haversine_distance #(
	parameter int ANGLE_FRAC_BITS = 20,
	parameter int CORDIC_STAGES = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	output logic                             busy,
	input  logic signed [hvd_pkg::LAT_W-1:0] lat_first,
	input  logic signed [hvd_pkg::LON_W-1:0] lon_first,
	input  logic signed [hvd_pkg::LAT_W-1:0] lat_second,
	input  logic signed [hvd_pkg::LON_W-1:0] lon_second,
	output logic                             done,
	output logic [hvd_pkg::DIST_W-1:0]       distance_m
);
	import hvd_pkg::*;

	localparam int NS  = CORDIC_STAGES;
	localparam int LAT = pipe_latency(NS);

	// the pipeline always advances, so requests are never refused
	assign busy = 1'b0;

	// valid chain: one bit per register layer, the last one is done
	logic [LAT-2:0] vld_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			done  <= 1'b0;
		end else begin
			vld_q <= {vld_q[LAT-3:0], start};
			done  <= vld_q[LAT-2];
		end
	end

	// front: half differences and doubled latitudes in the 2^(G) unit
	logic signed [ANG_W-1:0] ang_s1 [4];

	always_ff @(posedge clk) begin
		ang_s1[0] <= ANG_W'(lat_second) - ANG_W'(lat_first);
		ang_s1[1] <= ANG_W'(lon_second) - ANG_W'(lon_first);
		ang_s1[2] <= ANG_W'(lat_first) <<< 1;
		ang_s1[3] <= ANG_W'(lat_second) <<< 1;
	end

	// four sine/cosine lanes: sin(dlat/2), sin(dlon/2), cos(lat1), cos(lat2)
	cq_t sc_sin [4];
	cq_t sc_cos [4];

	for (genvar l = 0; l < 4; l++) begin : g_lane
		hvd_sincos #(
			.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS),
			.CORDIC_STAGES   (CORDIC_STAGES)
		) u_sincos (
			.clk     (clk),
			.angle   (ang_s1[l]),
			.sin_val (sc_sin[l]),
			.cos_val (sc_cos[l])
		);
	end

	// haversine term: raw squares and cosine product
	prod_t uu_s2, vv_s2, cc_s2;

	always_ff @(posedge clk) begin
		uu_s2 <= prod_t'(sc_sin[0]) * prod_t'(sc_sin[0]);
		vv_s2 <= prod_t'(sc_sin[1]) * prod_t'(sc_sin[1]);
		cc_s2 <= prod_t'(sc_cos[2]) * prod_t'(sc_cos[3]);
	end

	// round each product back to Q30
	cq_t uu_s3, vv_s3, cc_s3;

	always_ff @(posedge clk) begin
		uu_s3 <= q30_round(uu_s2);
		vv_s3 <= q30_round(vv_s2);
		cc_s3 <= q30_round(cc_s2);
	end

	// cos1*cos2 times sin^2(dlon/2)
	prod_t ccvv_s4;
	cq_t   uu_s4;

	always_ff @(posedge clk) begin
		ccvv_s4 <= prod_t'(cc_s3) * prod_t'(vv_s3);
		uu_s4   <= uu_s3;
	end

	// sum and clamp to [0,1]; a latitude past the pole can push it negative
	localparam logic [SQ_W-1:0] ONE_Q30 = SQ_W'(64'd1 << Q30_FRAC);

	logic signed [CQ_W:0] asum_c;
	logic [SQ_W-1:0]      a_c;

	always_comb begin
		asum_c = (CQ_W+1)'(uu_s4) + (CQ_W+1)'(q30_round(ccvv_s4));
		if (asum_c < 0) begin
			a_c = '0;
		end else if (asum_c > $signed((CQ_W+1)'(ONE_Q30))) begin
			a_c = ONE_Q30;
		end else begin
			a_c = asum_c[SQ_W-1:0];
		end
	end

	// square roots of a (lane 0) and 1-a (lane 1), one root bit per stage,
	// then round to nearest
	logic [SQ_W-1:0] sq_in_c [2];
	logic [SQ_W-1:0] sres_c  [2];

	assign sq_in_c[0] = a_c;
	assign sq_in_c[1] = ONE_Q30 - a_c;

	for (genvar l = 0; l < 2; l++) begin : g_sqrt
		logic [SQ_REM_W-1:0] rem_s5  [0:SQ_STEPS];
		logic [SQ_W-1:0]     root_s5 [0:SQ_STEPS];

		always_ff @(posedge clk) begin
			rem_s5[0]  <= {sq_in_c[l], 30'b0};
			root_s5[0] <= '0;
		end

		for (genvar j = 0; j < SQ_STEPS; j++) begin : g_step
			localparam int K = SQ_STEPS - 1 - j;
			logic [SQ_REM_W:0] trial;

			assign trial = ((SQ_REM_W+1)'(root_s5[j]) << (K + 1)) |
				((SQ_REM_W+1)'(1) << (2 * K));

			always_ff @(posedge clk) begin
				if ({1'b0, rem_s5[j]} >= trial) begin
					rem_s5[j+1]  <= rem_s5[j] - SQ_REM_W'(trial);
					root_s5[j+1] <= root_s5[j] | (SQ_W'(1) << K);
				end else begin
					rem_s5[j+1]  <= rem_s5[j];
					root_s5[j+1] <= root_s5[j];
				end
			end
		end

		assign sres_c[l] = root_s5[SQ_STEPS] +
			SQ_W'(rem_s5[SQ_STEPS] > SQ_REM_W'(root_s5[SQ_STEPS]));
	end

	// vectoring CORDIC: angle of (sqrt(1-a), sqrt(a)) gives asin(sqrt(a))
	cq_t vx_s6 [0:NS];
	cq_t vy_s6 [0:NS];
	cq_t vz_s6 [0:NS];

	always_ff @(posedge clk) begin
		vx_s6[0] <= cq_t'({2'b00, sres_c[1]});
		vy_s6[0] <= cq_t'({2'b00, sres_c[0]});
		vz_s6[0] <= '0;
	end

	for (genvar i = 0; i < NS; i++) begin : g_vec
		always_ff @(posedge clk) begin
			if (vy_s6[i] > 0) begin
				vx_s6[i+1] <= vx_s6[i] + (vy_s6[i] >>> i);
				vy_s6[i+1] <= vy_s6[i] - (vx_s6[i] >>> i);
				vz_s6[i+1] <= vz_s6[i] + atan_q30(i);
			end else begin
				vx_s6[i+1] <= vx_s6[i] - (vy_s6[i] >>> i);
				vy_s6[i+1] <= vy_s6[i] + (vx_s6[i] >>> i);
				vz_s6[i+1] <= vz_s6[i] - atan_q30(i);
			end
		end
	end

	// scale by the diameter; drop a slightly negative settled angle to zero
	localparam int DP_W = 31 + DIAM_W;

	logic [30:0]     zc_c;
	logic [DP_W-1:0] dp_s7;

	assign zc_c = (vz_s6[NS] < 0) ? '0 : vz_s6[NS][30:0];

	always_ff @(posedge clk) begin
		dp_s7 <= DP_W'(zc_c) * DP_W'(DIAMETER_M);
	end

	// round to whole metres and saturate at half the circumference
	logic [DP_W:0]        dsum_c;
	logic [DP_W-Q30_FRAC:0] dr_c;

	always_comb begin
		dsum_c = {1'b0, dp_s7} + ((DP_W+1)'(1) << (Q30_FRAC - 1));
		dr_c   = dsum_c[DP_W:Q30_FRAC];
	end

	always_ff @(posedge clk) begin
		if (dr_c > (DP_W-Q30_FRAC+1)'(DIST_MAX)) begin
			distance_m <= DIST_MAX;
		end else begin
			distance_m <= dr_c[DIST_W-1:0];
		end
	end

endmodule

### rtl/hvd_checker.sv
// ---------------------------------------------------------------------------
// Haversine distance port checker
// Watches the request and result ports of the distance pipeline.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "haversine_distance_macros.svh"

module hvd_checker #(
	parameter int CORDIC_STAGES = 32
) (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        start,
	input logic                        busy,
	input logic                        done,
	input logic [hvd_pkg::DIST_W-1:0]  distance_m
);
	import hvd_pkg::*;

	localparam int LAT = pipe_latency(CORDIC_STAGES);

	// every result traces back to a request a fixed latency earlier
	`HVD_ASSERT(a_done_has_req, clk, arst_n, done, $past(start && !busy, LAT), "result without request")
	// nothing leaves the pipe on the first cycle out of reset
	`HVD_ASSERT(a_reset_quiet, clk, arst_n, !$past(arst_n), !done, "result straight after reset")
	// distance never exceeds half the circumference
	`HVD_ASSERT(a_dist_range, clk, arst_n, done, distance_m <= DIST_MAX, "distance out of range")
	// a request never blocks the next one
	`HVD_ASSERT_NEXT(a_back_to_back, clk, arst_n, start && !busy, !busy, "request refused after request")

endmodule

bind haversine_distance hvd_checker #(.CORDIC_STAGES(CORDIC_STAGES)) u_hvd_checker (.*);
